// ----- src/iexp_pkg.sv -----
// Shared types, constants and codes for the infix integer expression evaluator.
package iexp_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	// Operator token codes.
	localparam logic [DATA_WIDTH-1:0] OP_ADD = DATA_WIDTH'(1);
	localparam logic [DATA_WIDTH-1:0] OP_SUB = DATA_WIDTH'(2);
	localparam logic [DATA_WIDTH-1:0] OP_MUL = DATA_WIDTH'(3);
	localparam logic [DATA_WIDTH-1:0] OP_DIV = DATA_WIDTH'(4);

	// Result status codes.
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_BAD_OP = 2'd1;
	localparam logic [1:0] STAT_DIV0   = 2'd2;
	localparam logic [1:0] STAT_END_OP = 2'd3;

	// Value reported with an error status: minimum signed value plus two or plus one.
	localparam logic [DATA_WIDTH-1:0] VAL_BAD_OP = {1'b1, {(DATA_WIDTH-1){1'b0}}} + DATA_WIDTH'(2);
	localparam logic [DATA_WIDTH-1:0] VAL_DIV0   = {1'b1, {(DATA_WIDTH-1){1'b0}}} + DATA_WIDTH'(1);

	// Pending multiplicative operation on the running term.
	typedef enum logic [1:0] {
		MD_NONE = 2'd0,
		MD_MUL  = 2'd1,
		MD_DIV  = 2'd2
	} muldiv_t;

	// Command from the sequencer to the shared arithmetic unit.
	typedef struct packed {
		logic    start;
		muldiv_t op;
	} alu_cmd_t;

	// Input beat.
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] token;
		logic                         is_last;
	} tok_beat_t;

	// Result beat.
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic [1:0]                   status;
	} res_beat_t;

endpackage

// ----- src/iexp_alu.sv -----
// Iterative shift-add multiplier and shift-subtract divider sharing one adder.
module iexp_alu (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iexp_pkg::alu_cmd_t             cmd,
	input  logic [iexp_pkg::DATA_WIDTH-1:0] opa,
	input  logic [iexp_pkg::DATA_WIDTH-1:0] opb,
	output logic                           done,
	output logic [iexp_pkg::DATA_WIDTH-1:0] result
);
	import iexp_pkg::*;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

	logic                  busy_q;
	logic                  done_q;
	logic                  is_div_q;
	logic                  neg_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] a_q;   // multiplicand, or dividend shifting into quotient
	logic [DATA_WIDTH-1:0] b_q;   // multiplier, or divisor magnitude
	logic [DATA_WIDTH-1:0] r_q;   // product accumulator, or partial remainder

	logic [DATA_WIDTH:0]   add_x;
	logic [DATA_WIDTH:0]   add_y;
	logic [DATA_WIDTH+1:0] add_sum;
	logic                  no_borrow;
	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;

	// Magnitudes of the operands for the divider.
	assign mag_a = opa[DATA_WIDTH-1] ? (~opa + DATA_WIDTH'(1)) : opa;
	assign mag_b = opb[DATA_WIDTH-1] ? (~opb + DATA_WIDTH'(1)) : opb;

	// The one shared adder: accumulate for multiply, trial subtract for divide.
	always_comb begin
		if (is_div_q) begin
			add_x = {r_q, a_q[DATA_WIDTH-1]};
			add_y = ~{1'b0, b_q};
		end else begin
			add_x = {1'b0, r_q};
			add_y = b_q[0] ? {1'b0, a_q} : '0;
		end
		add_sum = {1'b0, add_x} + {1'b0, add_y} + (DATA_WIDTH+2)'(is_div_q);
	end

	assign no_borrow = add_sum[DATA_WIDTH+1];

	// Step sequencing and operand shifting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			is_div_q <= 1'b0;
			neg_q    <= 1'b0;
			cnt_q    <= '0;
			a_q      <= '0;
			b_q      <= '0;
			r_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q   <= 1'b1;
				cnt_q    <= '0;
				r_q      <= '0;
				is_div_q <= (cmd.op == MD_DIV);
				neg_q    <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
				if (cmd.op == MD_DIV) begin
					a_q <= mag_a;
					b_q <= mag_b;
				end else begin
					a_q <= opa;
					b_q <= opb;
				end
			end else if (busy_q) begin
				if (is_div_q) begin
					r_q <= no_borrow ? add_sum[DATA_WIDTH-1:0] : add_x[DATA_WIDTH-1:0];
					a_q <= {a_q[DATA_WIDTH-2:0], no_borrow};
				end else begin
					r_q <= add_sum[DATA_WIDTH-1:0];
					a_q <= {a_q[DATA_WIDTH-2:0], 1'b0};
					b_q <= {1'b0, b_q[DATA_WIDTH-1:1]};
				end
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Final result: low product word, or signed quotient truncated toward zero.
	assign done   = done_q;
	assign result = !is_div_q ? r_q : (neg_q ? (~a_q + DATA_WIDTH'(1)) : a_q);

endmodule

// ----- src/infix_integer_expression_evaluator_core.sv -----
// Top level: token sequencer, running sum and term, and the result register.
//
//  Channel | Signals                          | Beat
//  --------+----------------------------------+-----------------------------
//  tok     | tok_valid, tok_stall, tok_beat   | token (32b signed), is_last
//  res     | res_valid, res_stall, res_beat   | value (32b signed), status
//
// Add, subtract, plain operands and operator tokens are handled in the idle state itself.
// An operand after multiply, or a nonzero divisor after divide, goes through
// 32 steps of the shared shift-add / shift-subtract unit plus start and write-back.
// A zero divisor does not start the unit and only latches its error.
// A last token then passes through the emit state to load the result register, and waits there
// while a previous result is still held under res_stall.
// After reset the block is ready at once; tok_stall is high while it works.
module infix_integer_expression_evaluator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_valid,
	output logic                tok_stall,
	input  iexp_pkg::tok_beat_t tok_beat,
	output logic                res_valid,
	input  logic                res_stall,
	output iexp_pkg::res_beat_t res_beat
);
	import iexp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [DATA_WIDTH-1:0] sum_q;
	logic [DATA_WIDTH-1:0] term_q;
	logic                  sign_q;
	muldiv_t               muldiv_q;
	logic                  expect_op_q;
	logic [1:0]            err_q;
	logic                  last_q;
	logic                  res_valid_q;
	res_beat_t             res_q;

	logic                  accept;
	logic                  slot_free;
	logic [DATA_WIDTH-1:0] tok;
	logic [DATA_WIDTH-1:0] total;
	logic                  is_add_sub;
	logic                  div_zero;
	alu_cmd_t              alu_cmd;
	logic                  alu_done;
	logic [DATA_WIDTH-1:0] alu_result;
	logic [1:0]            fin_status;
	logic [DATA_WIDTH-1:0] fin_value;

	assign tok       = tok_beat.token;
	assign accept    = tok_valid && !tok_stall;
	assign tok_stall = (state_q != ST_IDLE);
	assign slot_free = !res_valid_q || !res_stall;

	// Sum with the open term folded in.
	assign total      = sign_q ? (sum_q - term_q) : (sum_q + term_q);
	assign is_add_sub = (tok == OP_ADD) || (tok == OP_SUB);
	assign div_zero   = (tok == '0);

	// Start the shared unit for an operand that multiplies or divides the term.
	always_comb begin
		alu_cmd.op    = muldiv_q;
		alu_cmd.start = accept && !expect_op_q &&
			((muldiv_q == MD_MUL) || ((muldiv_q == MD_DIV) && !div_zero));
	end

	iexp_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.opa    (term_q),
		.opb    (tok),
		.done   (alu_done),
		.result (alu_result)
	);

	// Final status and value; an operator as last token leaves expect_op_q low.
	always_comb begin
		if (err_q != STAT_OK) begin
			fin_status = err_q;
		end else if (!expect_op_q) begin
			fin_status = STAT_END_OP;
		end else begin
			fin_status = STAT_OK;
		end
		case (fin_status)
			STAT_BAD_OP: fin_value = VAL_BAD_OP;
			STAT_DIV0:   fin_value = VAL_DIV0;
			STAT_END_OP: fin_value = '0;
			default:     fin_value = total;
		endcase
	end

	// Sequencer, expression state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			term_q      <= '0;
			sign_q      <= 1'b0;
			muldiv_q    <= MD_NONE;
			expect_op_q <= 1'b0;
			err_q       <= STAT_OK;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall && (state_q != ST_EMIT)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= tok_beat.is_last;
						if (!expect_op_q) begin
							// Operand beat.
							expect_op_q <= 1'b1;
							if (alu_cmd.start) begin
								state_q <= ST_CALC;
							end else begin
								if (muldiv_q == MD_NONE) begin
									term_q <= tok;
								end else if (err_q == STAT_OK) begin
									err_q <= STAT_DIV0;
								end
								if (tok_beat.is_last) begin
									state_q <= ST_EMIT;
								end
							end
						end else begin
							// Operator beat.
							expect_op_q <= 1'b0;
							if (is_add_sub) begin
								sum_q    <= total;
								term_q   <= '0;
								sign_q   <= (tok == OP_SUB);
								muldiv_q <= MD_NONE;
							end else if (tok == OP_MUL) begin
								muldiv_q <= MD_MUL;
							end else if (tok == OP_DIV) begin
								muldiv_q <= MD_DIV;
							end else if (err_q == STAT_OK) begin
								err_q <= STAT_BAD_OP;
							end
							if (tok_beat.is_last) begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_CALC: begin
					if (alu_done) begin
						term_q  <= alu_result;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						res_valid_q  <= 1'b1;
						res_q.value  <= fin_value;
						res_q.status <= fin_status;
						state_q      <= ST_IDLE;
						sum_q        <= '0;
						term_q       <= '0;
						sign_q       <= 1'b0;
						muldiv_q     <= MD_NONE;
						expect_op_q  <= 1'b0;
						err_q        <= STAT_OK;
						last_q       <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_q;

	// A new result is only loaded out of the emit state.
	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_EMIT))
		else $error("result appeared without an emit step");

	// The shared unit only finishes while the sequencer waits for it.
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == ST_CALC))
		else $error("arithmetic unit finished outside the calc state");

	// Divide-by-zero results carry their fixed marker value.
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_beat.status == STAT_DIV0) |-> (res_beat.value == VAL_DIV0))
		else $error("divide-by-zero result has wrong value");

	// The unit is never started while the block is busy.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		alu_cmd.start |-> (state_q == ST_IDLE) && $past(!alu_done || state_q != ST_IDLE))
		else $error("arithmetic unit started while busy");

endmodule

// ----- verif/infix_integer_expression_evaluator_core_tb.sv -----
// Testbench for the infix integer expression evaluator: token stimulus, result prediction, checks.
module infix_integer_expression_evaluator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iexp_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      tok_valid = 1'b0;
	logic      tok_stall;
	tok_beat_t tok_beat = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_beat_t res_beat;

	// Shadow copy of the evaluator state.
	logic [DW-1:0] sum_run;
	logic [DW-1:0] term_run;
	logic          sub_next;
	muldiv_t       md_next;
	logic          want_operator;
	logic [1:0]    err_latched;

	res_beat_t     pending_results[$];
	logic [DW-1:0] expr_toks[$];
	bit            idle_en = 1'b1;
	int            fail_count = 0;

	infix_integer_expression_evaluator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_beat(tok_beat),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_beat(res_beat)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void log_failure(input string msg);
		if (fail_count < 10) begin
			$display("[%0t] %s", $realtime, msg);
		end
		fail_count++;
	endfunction

	function automatic void clear_predictor();
		sum_run = '0;
		term_run = '0;
		sub_next = 1'b0;
		md_next = MD_NONE;
		want_operator = 1'b0;
		err_latched = STAT_OK;
	endfunction

	// Signed division that truncates toward zero and wraps at the data width.
	function automatic logic [DW-1:0] trunc_div(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW-1:0] mag_a;
		logic [DW-1:0] mag_b;
		logic [DW-1:0] quo;
		mag_a = a[DW-1] ? -a : a;
		mag_b = b[DW-1] ? -b : b;
		quo = mag_a / mag_b;
		return (a[DW-1] != b[DW-1]) ? -quo : quo;
	endfunction

	function automatic logic [DW-1:0] running_total();
		return sub_next ? sum_run - term_run : sum_run + term_run;
	endfunction

	// Fold one accepted token into the shadow state; the last token yields a result.
	function automatic void fold_token(input tok_beat_t b);
		logic [DW-1:0] tok;
		logic          was_op;
		res_beat_t     r;
		tok = b.token;
		was_op = want_operator;
		if (!was_op) begin
			case (md_next)
				MD_MUL: term_run = term_run * tok;
				MD_DIV: begin
					if (tok == '0) begin
						if (err_latched == STAT_OK)
							err_latched = STAT_DIV0;
					end else begin
						term_run = trunc_div(term_run, tok);
					end
				end
				default: term_run = tok;
			endcase
			want_operator = 1'b1;
		end else begin
			if (tok == OP_ADD || tok == OP_SUB) begin
				sum_run = running_total();
				term_run = '0;
				sub_next = (tok == OP_SUB);
				md_next = MD_NONE;
			end else if (tok == OP_MUL) begin
				md_next = MD_MUL;
			end else if (tok == OP_DIV) begin
				md_next = MD_DIV;
			end else if (err_latched == STAT_OK) begin
				err_latched = STAT_BAD_OP;
			end
			want_operator = 1'b0;
		end
		if (b.is_last) begin
			r.status = err_latched;
			if (r.status == STAT_OK && was_op)
				r.status = STAT_END_OP;
			case (r.status)
				STAT_BAD_OP: r.value = VAL_BAD_OP;
				STAT_DIV0:   r.value = VAL_DIV0;
				STAT_END_OP: r.value = '0;
				default:     r.value = running_total();
			endcase
			pending_results.push_back(r);
			clear_predictor();
		end
	endfunction

	// Receiver side: random stall bursts while idling is enabled.
	initial begin : res_stall_gen
		int n;
		forever begin
			@(posedge clk);
			if (idle_en && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 7);
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Compare every accepted result beat with the oldest expectation.
	always @(posedge clk) begin : check_results
		res_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				log_failure($sformatf("unexpected result beat: value %0d status %0d",
					$signed(res_beat.value), res_beat.status));
			end else begin
				want = pending_results.pop_front();
				if (res_beat.value !== want.value || res_beat.status !== want.status) begin
					log_failure($sformatf("mismatch: expected value %0d status %0d, got value %0d status %0d",
						$signed(want.value), want.status, $signed(res_beat.value), res_beat.status));
				end
			end
		end
	end

	// Send one token beat, with an optional random gap before it.
	task automatic send_token(input logic [DW-1:0] tok, input logic last);
		tok_beat_t b;
		int        gap;
		b.token = tok;
		b.is_last = last;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			tok_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok_valid <= 1'b1;
		tok_beat <= b;
		@(posedge clk);
		while (tok_stall) @(posedge clk);
		fold_token(b);
	endtask

	task automatic send_expression();
		for (int i = 0; i < expr_toks.size(); i++) begin
			send_token(expr_toks[i], i == expr_toks.size() - 1);
		end
		expr_toks.delete();
	endtask

	function automatic logic [DW-1:0] pick_operand();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3: return DW'($urandom_range(0, 40)) - DW'(20);
			4, 5: return DW'($urandom());
			6: begin
				case ($urandom_range(0, 4))
					0: return MIN_VAL;
					1: return MAX_VAL;
					2: return '1;
					3: return '0;
					default: return DW'(1);
				endcase
			end
			default: return DW'($urandom_range(0, 200000)) - DW'(100000);
		endcase
	endfunction

	// Mostly valid operator codes, now and then an invalid one.
	function automatic logic [DW-1:0] pick_operator();
		int sel;
		sel = $urandom_range(0, 29);
		if (sel < 8)
			return OP_ADD;
		else if (sel < 15)
			return OP_SUB;
		else if (sel < 22)
			return OP_MUL;
		else if (sel < 29)
			return OP_DIV;
		else if ($urandom_range(0, 1) == 0)
			return ($urandom_range(0, 1) == 0) ? '0 : DW'($urandom_range(5, 9));
		else
			return DW'($urandom());
	endfunction

	// Build one random expression; a few of them stop on an operator.
	function automatic void build_expression();
		int n_operands;
		n_operands = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
		expr_toks.push_back(pick_operand());
		for (int i = 1; i < n_operands; i++) begin
			expr_toks.push_back(pick_operator());
			expr_toks.push_back(pick_operand());
		end
		if ($urandom_range(0, 11) == 0)
			expr_toks.push_back(pick_operator());
	endfunction

	// Extremes, every operator, precedence and each error case.
	task automatic test_directed();
		// Largest operand plus one wraps to the smallest.
		expr_toks = '{MAX_VAL, OP_ADD, DW'(1)};
		send_expression();
		// Precedence: 2 + 3 * 4 - 10.
		expr_toks = '{DW'(2), OP_ADD, DW'(3), OP_MUL, DW'(4), OP_SUB, DW'(10)};
		send_expression();
		// Division of a negative value truncates toward zero.
		expr_toks = '{-DW'(7), OP_DIV, DW'(2)};
		send_expression();
		// Smallest value divided by minus one wraps.
		expr_toks = '{MIN_VAL, OP_DIV, '1};
		send_expression();
		// Divide by zero.
		expr_toks = '{DW'(5), OP_DIV, '0};
		send_expression();
		// Invalid operator code with every bit set.
		expr_toks = '{DW'(1), '1, DW'(2)};
		send_expression();
		// Stream that ends on an operator.
		expr_toks = '{DW'(4), OP_ADD};
		send_expression();
		// The first error latches; a later bad code is not recorded.
		expr_toks = '{DW'(1), OP_DIV, '0, '0, DW'(3)};
		send_expression();
	endtask

	task automatic test_random_expressions();
		int sent;
		int k;
		sent = 0;
		k = 0;
		while (sent < 950) begin
			if (k % 16 == 0)
				idle_en = ($urandom_range(0, 3) != 0);
			k++;
			build_expression();
			sent += expr_toks.size();
			send_expression();
		end
	endtask

	// Closing stretch with no gaps and no stalls.
	task automatic test_back_to_back();
		int sent;
		sent = 0;
		idle_en = 1'b0;
		while (sent < 150) begin
			build_expression();
			sent += expr_toks.size();
			send_expression();
		end
		tok_valid <= 1'b0;
	endtask

	initial begin : main
		int waited;
		clear_predictor();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_expressions();
		test_back_to_back();

		// Drain the remaining results, then allow for stray beats.
		waited = 0;
		while (pending_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0)
			log_failure($sformatf("%0d expected results never arrived", pending_results.size()));

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
